@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define KEVG_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define KEVG_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds through reset.
`define KEVG_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/kevg_pkg.sv @@
// Types, constants and helpers of the key event generator.
`timescale 1ns / 1ps
package kevg_pkg;

  localparam int NUM_KEYS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LEVEL_W         = 8;
  localparam int CNT_W           = 15;
  localparam int TICK_W          = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 14;

  localparam logic [CNT_W-1:0] COUNT_SAT = 15'h7FFE;

  localparam logic [1:0] EV_DOWN   = 2'd0;
  localparam logic [1:0] EV_UP     = 2'd1;
  localparam logic [1:0] EV_HOLD   = 2'd2;
  localparam logic [1:0] EV_REPEAT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_UP  = 3'd4;

  localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 14'd200;
  localparam logic [TICK_W-1:0] REPEAT_TICKS_RST = 14'd30;
  localparam logic [3:0]        EVENT_ENABLE_RST = 4'hF;

  typedef struct packed {
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] repeat_ticks;
    logic [3:0]        event_enable;
    logic              global_mask;
    logic              suppress_up_after_hold;
  } cfg_t;

  function automatic logic emit_ok(input cfg_t cfg, input logic [1:0] kind);
    return cfg.event_enable[kind] && !cfg.global_mask;
  endfunction

endpackage

@@ src/kevg_in_if.sv @@
// Input channel: one scan tick of key levels per word.
`timescale 1ns / 1ps
interface kevg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink (input valid, input key_levels, output ready);
endinterface

@@ src/kevg_out_if.sv @@
// Output channel: one key event per word.
`timescale 1ns / 1ps
interface kevg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_index;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output key_index, output event_kind, output last_event,
                  input ready);
  modport sink (input valid, input key_index, input event_kind, input last_event,
                output ready);
endinterface

@@ src/kevg_queue.sv @@
// Short queue of per-tick event sets between the front and back parts.
`timescale 1ns / 1ps
module kevg_queue import kevg_pkg::*; #(
  parameter int WIDTH = 3 * NUM_KEYS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_QW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

@@ src/kevg_front.sv @@
// Front part: takes a scan tick, updates every key's state and classifies its events.
`timescale 1ns / 1ps
module kevg_front import kevg_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  kevg_in_if.sink                  key_in,
  input  cfg_t                     cfg,
  output logic                     push_valid,
  output logic [NUM_KEYS-1:0]      push_mask,
  output logic [NUM_KEYS-1:0][1:0] push_kinds,
  input  logic                     push_ready
);

  logic [NUM_KEYS-1:0]            level;
  logic [NUM_KEYS-1:0]            level_next;
  logic [NUM_KEYS-1:0][CNT_W-1:0] cnt;
  logic [NUM_KEYS-1:0][CNT_W-1:0] cnt_next;
  logic [NUM_KEYS-1:0]            sup;
  logic [NUM_KEYS-1:0]            sup_next;
  logic [CNT_W-1:0]               hold_c;
  logic [CNT_W-1:0]               rep_lim;
  logic                           accept;

  assign key_in.ready = push_ready;
  assign accept       = key_in.valid && push_ready;
  assign hold_c       = {1'b0, cfg.hold_ticks};
  assign rep_lim      = hold_c + {1'b0, cfg.repeat_ticks};
  assign push_valid   = accept && (push_mask != '0);

  always_comb begin
    logic             lv;
    logic [CNT_W-1:0] c;
    for (int k = 0; k < NUM_KEYS; k++) begin
      // Keys past the input word always read as released.
      lv = (k < LEVEL_W) ? key_in.key_levels[k % LEVEL_W] : 1'b1;
      c  = cnt[k];
      level_next[k] = level[k];
      sup_next[k]   = sup[k];
      push_mask[k]  = 1'b0;
      push_kinds[k] = EV_DOWN;

      if (lv == level[k]) begin
        if (c < COUNT_SAT) begin
          c = (c == '0) ? CNT_W'(2) : c + CNT_W'(1);
        end
      end else begin
        level_next[k] = lv;
        c = CNT_W'(1);
      end

      if (!lv) begin
        if (c == CNT_W'(1)) begin
          push_mask[k]  = emit_ok(cfg, EV_DOWN);
          push_kinds[k] = EV_DOWN;
          sup_next[k]   = 1'b0;
          c = '0;
        end else if (c > CNT_W'(1)) begin
          if (c == hold_c) begin
            push_mask[k]  = emit_ok(cfg, EV_HOLD);
            push_kinds[k] = EV_HOLD;
            sup_next[k]   = 1'b1;
            c = c + CNT_W'(1);
          end else if (c >= rep_lim) begin
            push_mask[k]  = emit_ok(cfg, EV_REPEAT);
            push_kinds[k] = EV_REPEAT;
            c = hold_c + CNT_W'(1);
          end
        end
      end else if (c == CNT_W'(1)) begin
        // A masked up event leaves the suppress bit alone; a dropped one clears it.
        if (emit_ok(cfg, EV_UP)) begin
          if (cfg.suppress_up_after_hold && sup[k]) begin
            sup_next[k] = 1'b0;
          end else begin
            push_mask[k]  = 1'b1;
            push_kinds[k] = EV_UP;
          end
        end
        c = '0;
      end
      cnt_next[k] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '1;
      cnt   <= '0;
      sup   <= '0;
    end else if (accept) begin
      level <= level_next;
      cnt   <= cnt_next;
      sup   <= sup_next;
    end
  end

endmodule

@@ src/kevg_back.sv @@
// Back part: sends a tick's events in key order, one word per cycle unless stalled.
`timescale 1ns / 1ps
module kevg_back import kevg_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pop_valid,
  input  logic [NUM_KEYS-1:0]      pop_mask,
  input  logic [NUM_KEYS-1:0][1:0] pop_kinds,
  output logic                     pop_ready,
  kevg_out_if.source               ev_out
);

  logic                     busy;
  logic [NUM_KEYS-1:0]      mask;
  logic [NUM_KEYS-1:0][1:0] kinds;
  logic [NUM_KEYS-1:0]      low;
  logic [NUM_KEYS-1:0]      rest;
  logic                     fire;
  logic                     last;

  // Isolate the lowest pending key.
  assign low  = mask & (~mask + NUM_KEYS'(1));
  assign rest = mask & ~low;
  assign last = (rest == '0);
  assign fire = busy && ev_out.ready;
  assign pop_ready = !busy || (fire && last);

  always_comb begin
    ev_out.key_index  = '0;
    ev_out.event_kind = EV_DOWN;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (low[k]) begin
        ev_out.key_index  = ev_out.key_index | 3'(k);
        ev_out.event_kind = ev_out.event_kind | kinds[k];
      end
    end
  end

  assign ev_out.valid      = busy;
  assign ev_out.last_event = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop_ready) begin
      busy <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      mask  <= pop_mask;
      kinds <= pop_kinds;
    end else if (fire) begin
      mask <= rest;
    end
  end

endmodule

@@ src/key_event_generator_core.sv @@
// Top level of the key event generator: configuration registers, front, queue, back.
//
//   channel   dir  handshake              word
//   key_in    in   valid / ready          key_levels[7:0], one scan tick
//   ev_out    out  valid / ready          key_index, event_kind, last_event
//   cfg       in   cfg_we, no wait        cfg_index, cfg_data
//
// One scan tick is accepted per cycle while the event queue has room.
// The back part sends a tick's events one after another; a tick with no events
// is not queued. The first event passes the event queue and the back register.
// The event queue holds QUEUE_DEPTH ticks, so a stalled output stalls key_in
// only once it is full. Reset restores the register defaults and all keys released.
`timescale 1ns / 1ps
module key_event_generator_core import kevg_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  kevg_in_if.sink               key_in,
  kevg_out_if.source            ev_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QW = 3 * NUM_KEYS;

  cfg_t                     cfg;
  logic                     push_valid;
  logic                     push_ready;
  logic [NUM_KEYS-1:0]      push_mask;
  logic [NUM_KEYS-1:0][1:0] push_kinds;
  logic                     pop_valid;
  logic                     pop_ready;
  logic [QW-1:0]            pop_data;
  logic [NUM_KEYS-1:0]      pop_mask;
  logic [NUM_KEYS-1:0][1:0] pop_kinds;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks             <= HOLD_TICKS_RST;
      cfg.repeat_ticks           <= REPEAT_TICKS_RST;
      cfg.event_enable           <= EVENT_ENABLE_RST;
      cfg.global_mask            <= 1'b0;
      cfg.suppress_up_after_hold <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_TICKS:   cfg.hold_ticks             <= cfg_data[TICK_W-1:0];
        REG_REPEAT_TICKS: cfg.repeat_ticks           <= cfg_data[TICK_W-1:0];
        REG_EVENT_ENABLE: cfg.event_enable           <= cfg_data[3:0];
        REG_GLOBAL_MASK:  cfg.global_mask            <= cfg_data[0];
        REG_SUPPRESS_UP:  cfg.suppress_up_after_hold <= cfg_data[0];
        default: ;
      endcase
    end
  end

  kevg_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_mask  (push_mask),
    .push_kinds (push_kinds),
    .push_ready (push_ready)
  );

  kevg_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  ({push_kinds, push_mask}),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  assign pop_mask  = pop_data[NUM_KEYS-1:0];
  assign pop_kinds = pop_data[QW-1:NUM_KEYS];

  kevg_back #(.NUM_KEYS(NUM_KEYS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_mask  (pop_mask),
    .pop_kinds (pop_kinds),
    .pop_ready (pop_ready),
    .ev_out    (ev_out)
  );

endmodule

@@ src/kevg_checker.sv @@
// Port-level checks of the key event generator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kevg_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] key_index,
  input logic [1:0] event_kind,
  input logic       last_event
);

  // A stalled word keeps its payload.
  `KEVG_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(key_index) && $stable(event_kind) && $stable(last_event), "stalled event word changed")

  // Nothing is offered right after reset.
  `KEVG_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst), !out_valid, "event offered after reset")

  // The events of one tick follow each other without a gap.
  `KEVG_ASSERT_NEXT(a_tick_burst, clk, rst, out_valid && out_ready && !last_event, out_valid, "gap inside a tick's events")

  // Within a tick, keys come in rising order.
  `KEVG_ASSERT_NEXT(a_key_order, clk, rst, out_valid && out_ready && !last_event, key_index > $past(key_index), "events of a tick out of key order")

endmodule

bind key_event_generator_core kevg_checker u_kevg_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (ev_out.valid),
  .out_ready  (ev_out.ready),
  .key_index  (ev_out.key_index),
  .event_kind (ev_out.event_kind),
  .last_event (ev_out.last_event)
);
